// ===== rtl/sorted_set_table_assert.svh =====
// Assertion macros for the sorted set table.
// Used by sorted_set_table.sv; expects signals named clock and reset in scope.
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ss_pkg.sv =====
// Shared types and constants for the sorted set table.
// No dependencies; imported by the interfaces, the cell and the top level.
package ss_pkg;

   localparam int ElemW = 32;
   localparam int CmdW  = 3;
   localparam int CfgW  = 7;

   localparam int DefCapacity = 64;
   localparam logic [CfgW-1:0] DefMaxCount = 7'd64;

   // Command codes
   localparam logic [CmdW-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CmdW-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CmdW-1:0] CMD_MEMBER  = 3'd2;
   localparam logic [CmdW-1:0] CMD_POP     = 3'd3;
   localparam logic [CmdW-1:0] CMD_RESTART = 3'd4;
   localparam logic [CmdW-1:0] CMD_NEXT    = 3'd5;

   // Per-cycle control broadcast to every cell
   typedef struct packed {
      logic capture;     // latch compare flags against the incoming key
      logic shift_up;    // insert: open a slot at the insertion point
      logic shift_down;  // remove: close the slot of the matching cell
   } cell_ctl_type;

endpackage

// ===== rtl/ss_req_if.sv =====
// Request channel interface: command and element with valid/ready.
// Depends on ss_pkg.
interface ss_req_if;
   import ss_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CmdW-1:0]         command;
   logic signed [ElemW-1:0] element;

   modport source (output valid, output command, output element, input ready);
   modport sink   (input valid, input command, input element, output ready);
endinterface

// ===== rtl/ss_rsp_if.sv =====
// Response channel interface: success flag, value and count with valid/ready.
// Depends on ss_pkg.
interface ss_rsp_if;
   import ss_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    success;
   logic signed [ElemW-1:0] value_out;
   logic [CfgW-1:0]         count;

   modport source (output valid, output success, output value_out, output count, input ready);
   modport sink   (input valid, input success, input value_out, input count, output ready);
endinterface

// ===== rtl/ss_cell.sv =====
// One slot of the sorted table: holds an element, compares it with the
// request key and shifts toward its neighbors. Depends on ss_pkg.
module ss_cell #(
   parameter int CellIndex = 0,
   parameter int CntW      = 7
) (
   input  logic                            clock,
   input  ss_pkg::cell_ctl_type            ctl,
   input  logic [CntW-1:0]                 count,
   input  logic signed [ss_pkg::ElemW-1:0] cmp_key,
   input  logic signed [ss_pkg::ElemW-1:0] ins_key,
   input  logic signed [ss_pkg::ElemW-1:0] left_value,
   input  logic                            left_lt,
   input  logic signed [ss_pkg::ElemW-1:0] right_value,
   output logic signed [ss_pkg::ElemW-1:0] value,
   output logic                            lt,
   output logic                            eq
);
   import ss_pkg::*;

   localparam logic [CntW-1:0] MyIdx = CntW'(CellIndex);

   logic signed [ElemW-1:0] value_ff, value_in;
   logic                    lt_ff, lt_in;
   logic                    eq_ff, eq_in;
   logic                    in_use;

   assign in_use = (MyIdx < count);

   // Compare flags, taken when the request is accepted
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctl.capture) begin
         lt_in = in_use && (value_ff < cmp_key);
         eq_in = in_use && (value_ff == cmp_key);
      end
   end

   // Shift: cells below the insertion/removal point keep their value
   always_comb begin
      value_in = value_ff;
      if (ctl.shift_up && !lt_ff) begin
         value_in = left_lt ? ins_key : left_value;
      end else if (ctl.shift_down && !lt_ff) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
endmodule

// ===== rtl/sorted_set_table.sv =====
// Sorted set table: a set of distinct signed 32-bit values kept ascending in a
// row of Capacity cells. When a request is accepted, every cell compares its
// value with the key in parallel and stores the result; then the command
// commits (cells shift one place up or down, the count and iterator update)
// and the response is loaded into the output register. A stalled response
// holds the commit until the output register is free, and no new request is
// taken until the previous one commits. max_count (csr_wr_data) must be
// written only while no request is in flight; the block does not enforce it.
module sorted_set_table #(
   parameter int Capacity = ss_pkg::DefCapacity
) (
   input  logic                       clock,
   input  logic                       reset,
   ss_req_if.sink                     req_ch,
   ss_rsp_if.source                   rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [ss_pkg::CfgW-1:0]    csr_wr_data
);
   import ss_pkg::*;

   `include "sorted_set_table_assert.svh"

   localparam int CntW = $clog2(Capacity + 1);
   localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CmpW = (CntW > CfgW) ? CntW : CfgW;
   localparam logic [CntW-1:0] CapCount = CntW'(Capacity);

   // Control and configuration registers
   logic                    busy_ff, busy_in;
   logic [CmdW-1:0]         cmd_ff;
   logic signed [ElemW-1:0] key_ff;
   logic [CntW-1:0]         count_ff, count_in;
   logic [CntW-1:0]         iter_ff, iter_in;
   logic [CfgW-1:0]         max_ff;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_success_ff;
   logic signed [ElemW-1:0] rsp_value_ff;
   logic [CfgW-1:0]         rsp_count_ff;

   // Cell row wiring
   logic signed [ElemW-1:0] cell_value [Capacity];
   logic [Capacity-1:0]     cell_lt;
   logic [Capacity-1:0]     cell_eq;
   cell_ctl_type            ctl;

   logic                    accept;
   logic                    commit;
   logic                    found;
   logic                    full;
   logic [IdxW-1:0]         rd_sel;
   logic signed [ElemW-1:0] rd_value;
   logic                    ok;
   logic signed [ElemW-1:0] val;
   logic                    do_up;
   logic                    do_down;

   assign accept = req_ch.valid && req_ch.ready;
   assign commit = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !busy_ff;

   // Cell chain
   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      logic signed [ElemW-1:0] left_v;
      logic signed [ElemW-1:0] right_v;
      logic                    left_l;
      if (i == 0) begin : g_first
         assign left_v = key_ff;
         assign left_l = 1'b1;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_l = cell_lt[i-1];
      end
      if (i == Capacity - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_inner
         assign right_v = cell_value[i+1];
      end
      ss_cell #(.CellIndex(i), .CntW(CntW)) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .cmp_key     (req_ch.element),
         .ins_key     (key_ff),
         .left_value  (left_v),
         .left_lt     (left_l),
         .right_value (right_v),
         .value       (cell_value[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i])
      );
   end

   assign found = |cell_eq;
   assign full  = (CmpW'(count_ff) >= CmpW'(max_ff)) || (count_ff >= CapCount);

   // Read select: top element for pop, iterator slot for next
   always_comb begin
      rd_sel = (cmd_ff == CMD_POP) ? IdxW'(count_ff - CntW'(1)) : IdxW'(iter_ff);
      rd_value = '0;
      for (int i = 0; i < Capacity; i++) begin
         if (IdxW'(i) == rd_sel) begin
            rd_value = rd_value | cell_value[i];
         end
      end
   end

   // Command decode at commit
   always_comb begin
      ok       = 1'b0;
      val      = '0;
      do_up    = 1'b0;
      do_down  = 1'b0;
      count_in = count_ff;
      iter_in  = iter_ff;
      case (cmd_ff)
         CMD_INSERT: begin
            if (!full) begin
               ok = 1'b1;
               if (!found) begin
                  do_up    = 1'b1;
                  count_in = count_ff + CntW'(1);
               end
            end
         end
         CMD_REMOVE: begin
            if (found) begin
               ok       = 1'b1;
               do_down  = 1'b1;
               count_in = count_ff - CntW'(1);
            end
         end
         CMD_MEMBER: begin
            ok = found;
         end
         CMD_POP: begin
            if (count_ff != '0) begin
               ok       = 1'b1;
               val      = rd_value;
               count_in = count_ff - CntW'(1);
            end
         end
         CMD_RESTART: begin
            ok      = 1'b1;
            iter_in = '0;
         end
         CMD_NEXT: begin
            if (iter_ff < count_ff) begin
               ok      = 1'b1;
               val     = rd_value;
               iter_in = iter_ff + CntW'(1);
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!commit) begin
         do_up    = 1'b0;
         do_down  = 1'b0;
         count_in = count_ff;
         iter_in  = iter_ff;
      end
   end

   always_comb begin
      ctl.capture    = accept;
      ctl.shift_up   = do_up;
      ctl.shift_down = do_down;
   end

   // Busy and response valid
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (commit) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         iter_ff      <= '0;
         max_ff       <= DefMaxCount;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         iter_ff      <= iter_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

   // Request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_ch.command;
         key_ff <= req_ch.element;
      end
      if (commit) begin
         rsp_success_ff <= ok;
         rsp_value_ff   <= val;
         rsp_count_ff   <= CfgW'(CmpW'(count_in));
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.success   = rsp_success_ff;
   assign rsp_ch.value_out = rsp_value_ff;
   assign rsp_ch.count     = rsp_count_ff;

   // Checks
   `SST_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= CapCount, "count above capacity")
   `SST_ASSERT_NEXT(a_count_hold, !commit, $stable(count_ff), "count moved without commit")
   `SST_ASSERT_NEXT(a_insert_grows, do_up, count_ff == $past(count_ff) + CntW'(1), "no growth")
endmodule

// ===== dv/set_table_checker.sv =====
`timescale 1ns / 100ps
// Response checker for sorted_set_table: keeps its own copy of the set, works out each response.
// Depends on ss_pkg and the ss_req_if / ss_rsp_if interfaces; instantiated by tb_sorted_set_table.
module set_table_checker (
   input  logic                    clock,
   input  logic                    reset,
   ss_req_if                       req_mon,
   ss_rsp_if                       rsp_mon,
   input  logic                    csr_wr_en,
   input  logic [ss_pkg::CfgW-1:0] csr_wr_data,
   output int                      mismatch_count,
   output int                      results_pending
);
   import ss_pkg::*;

   typedef struct packed {
      logic                    success;
      logic signed [ElemW-1:0] value_out;
      logic [CfgW-1:0]         count;
   } set_result_type;

   // Shadow of the table: ascending members, iterator and limit register
   logic signed [ElemW-1:0] members[$];
   int                      iter_pos;
   logic [CfgW-1:0]         max_count;
   set_result_type          expected_q[$];

   // Apply one request to the shadow set and return the response it should give
   function automatic set_result_type predict_set_op(input logic [CmdW-1:0] cmd,
                                                     input logic signed [ElemW-1:0] key);
      set_result_type res;
      int             pos;
      int             limit;
      bit             hit;
      res = '0;
      pos = 0;
      while (pos < members.size() && members[pos] < key) pos++;
      hit = (pos < members.size()) && (members[pos] == key);
      limit = (max_count < DefCapacity) ? int'(max_count) : DefCapacity;
      case (cmd)
         CMD_INSERT: begin
            // full table refuses even a duplicate
            if (members.size() < limit) begin
               if (!hit) members.insert(pos, key);
               res.success = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               members.delete(pos);
               res.success = 1'b1;
            end
         end
         CMD_MEMBER: res.success = hit;
         CMD_POP: begin
            if (members.size() > 0) begin
               res.value_out = members.pop_back();
               res.success   = 1'b1;
            end
         end
         CMD_RESTART: begin
            iter_pos    = 0;
            res.success = 1'b1;
         end
         CMD_NEXT: begin
            // iterator position is held against the current count
            if (iter_pos < members.size()) begin
               res.value_out = members[iter_pos];
               iter_pos++;
               res.success = 1'b1;
            end
         end
         default: ;
      endcase
      res.count = CfgW'(members.size());
      return res;
   endfunction

   // Responses are checked before the same-edge request is predicted
   always @(posedge clock) begin : monitor
      set_result_type want;
      if (reset) begin
         members.delete();
         expected_q.delete();
         iter_pos        = 0;
         max_count       = DefMaxCount;
         mismatch_count  = 0;
         results_pending = 0;
      end else begin
         if (csr_wr_en) max_count = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with none outstanding: %0b %0d %0d",
                           $realtime, rsp_mon.success, rsp_mon.value_out, rsp_mon.count);
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.success !== want.success || rsp_mon.value_out !== want.value_out ||
                   rsp_mon.count !== want.count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch: expected %0b %0d %0d, got %0b %0d %0d",
                              $realtime, want.success, want.value_out, want.count,
                              rsp_mon.success, rsp_mon.value_out, rsp_mon.count);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(predict_set_op(req_mon.command, req_mon.element));
         results_pending = expected_q.size();
      end
   end

endmodule

// ===== dv/tb_sorted_set_table.sv =====
`timescale 1ns / 100ps
// Testbench top for sorted_set_table: clock, reset, request stimulus, response stalls, verdict.
// Depends on ss_pkg, ss_req_if, ss_rsp_if, sorted_set_table and set_table_checker.
module tb_sorted_set_table;
   import ss_pkg::*;

   localparam logic [CmdW-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [CmdW-1:0] CMD_RSVD7 = 3'd7;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 155;
   localparam int POOL_SIZE    = 48;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 400000;

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   logic [CfgW-1:0] csr_wr_data;
   int              mismatch_count;
   int              results_pending;
   int              cycle_count;
   bit              idle_on;
   bit              hold_rsp;

   logic signed [ElemW-1:0] elem_pool [POOL_SIZE];
   // limit per phase: over capacity, lowered below a full set, zero, one, ...
   logic [CfgW-1:0] limit_plan [NUM_PHASES] = '{7'd127, 7'd3, 7'd0, 7'd1,
                                                7'd64, 7'd17, 7'd100, 7'd64};
   int              insert_pct [NUM_PHASES] = '{75, 20, 40, 45, 60, 50, 65, 35};

   ss_req_if req_ch();
   ss_rsp_if rsp_ch();

   sorted_set_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   set_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_set_table regression: fail");
      $finish;
   end

   // Response ready: random stalls while idling is on, or a long hold when asked
   initial begin : rsp_ready_drive
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_rsp) begin
            hold_rsp     = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   // Offer one request from a falling edge and return at the falling edge after acceptance
   task automatic send_req(input logic [CmdW-1:0] cmd, input logic signed [ElemW-1:0] elem);
      while (idle_on && $urandom_range(0, 99) < 24) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.element <= elem;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [CfgW-1:0] lim);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [CmdW-1:0] pick_command(input int ins_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct) return CMD_INSERT;
      r = $urandom_range(0, 99);
      if (r < 25) return CMD_REMOVE;
      if (r < 45) return CMD_MEMBER;
      if (r < 60) return CMD_POP;
      if (r < 68) return CMD_RESTART;
      if (r < 96) return CMD_NEXT;
      if (r < 98) return CMD_RSVD6;
      return CMD_RSVD7;
   endfunction

   // Mostly pool values so removes and member tests hit, plus small values near zero and full-width noise
   function automatic logic signed [ElemW-1:0] pick_element();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return elem_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 65) return int'($urandom_range(0, 8)) - 4;
      return $urandom;
   endfunction

   initial begin : stimulus
      int i;
      int p;
      int n;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_INSERT;
      req_ch.element = '0;
      idle_on        = 1'b1;
      hold_rsp       = 1'b0;
      elem_pool[0] = 32'sh8000_0000;
      elem_pool[1] = 32'sh7fff_ffff;
      elem_pool[2] = 32'sd0;
      elem_pool[3] = -32'sd1;
      elem_pool[4] = 32'sd1;
      for (i = 5; i < POOL_SIZE; i++) elem_pool[i] = $urandom;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty set, extremes, duplicates, iterator walk and overrun, bad codes
      send_req(CMD_MEMBER, 32'sd0);
      send_req(CMD_POP, 32'sd0);
      send_req(CMD_NEXT, 32'sd0);
      send_req(CMD_REMOVE, 32'sd5);
      send_req(CMD_INSERT, 32'sh8000_0000);
      send_req(CMD_INSERT, 32'sh7fff_ffff);
      send_req(CMD_INSERT, 32'sd0);
      send_req(CMD_INSERT, -32'sd1);
      send_req(CMD_INSERT, 32'sd1);
      send_req(CMD_INSERT, 32'sh7fff_ffff);
      send_req(CMD_MEMBER, 32'sh8000_0000);
      send_req(CMD_MEMBER, 32'sd2);
      send_req(CMD_RESTART, 32'sd0);
      send_req(CMD_NEXT, 32'sd0);
      send_req(CMD_NEXT, 32'sd0);
      send_req(CMD_REMOVE, 32'sd0);
      send_req(CMD_NEXT, 32'sd0);
      send_req(CMD_POP, 32'sd0);
      send_req(CMD_NEXT, 32'sd0);
      send_req(CMD_RSVD6, 32'sd5);
      send_req(CMD_RSVD7, -32'sd1);
      send_req(CMD_REMOVE, 32'sd0);
      // limit below the current count: even a duplicate insert is refused
      wait_idle();
      write_limit(7'd2);
      send_req(CMD_INSERT, -32'sd1);
      send_req(CMD_REMOVE, -32'sd1);
      send_req(CMD_INSERT, 32'sd7);
      send_req(CMD_REMOVE, 32'sd1);
      send_req(CMD_INSERT, 32'sd7);

      // Random phases, one limit setting each; phase 4 runs without idling
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_limit(limit_plan[p]);
         idle_on = (p != 4);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ((p == 1 || p == 6) && n == 20) hold_rsp = 1'b1;
            send_req(pick_command(insert_pct[p]), pick_element());
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("sorted_set_table regression: pass");
      end else begin
         $display("sorted_set_table regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ss_pkg.sv
rtl/ss_req_if.sv
rtl/ss_rsp_if.sv
rtl/ss_cell.sv
rtl/sorted_set_table.sv
dv/set_table_checker.sv
dv/tb_sorted_set_table.sv
